// File: rtl/vwnm_pkg.sv
// Shared types, constants and helpers for the vertex weld / normal merge block.
package vwnm_pkg;

  localparam int CAPACITY_DEF  = 1024;
  localparam int SUM_WIDTH_DEF = 24;

  localparam int IDXW = 10;   // index fields on the channels
  localparam int QW   = 15;   // unit normal magnitude, 0..16384
  localparam int RHSW = 60;   // a^2 * 2^30

  localparam logic [QW-1:0] Q_ONE    = 15'd16384;
  localparam logic [31:0]   NEG_ZERO = 32'h8000_0000;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] ST_NEW    = 2'd0;
  localparam logic [1:0] ST_MATCH  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_BADIDX = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SUM_RD, S_SUM_WR, S_NEW, S_RD_WAIT,
    S_SHIFT, S_SQ, S_NSUM, S_FEED, S_DRAIN, S_DONE
  } vwnm_state_t;

  // one component travelling down the root-finding chain
  typedef struct packed {
    logic            valid;
    logic [1:0]      tag;
    logic [QW-1:0]   q;
    logic [RHSW-1:0] rhs;
    logic [31:0]     n;
  } vwnm_cell_t;

  function automatic logic [31:0] canon(input logic [31:0] v);
    return (v == NEG_ZERO) ? 32'd0 : v;
  endfunction

endpackage

// File: rtl/vwnm_if.sv
// Request and result channel interfaces.
interface vwnm_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [31:0]        pos_x;
  logic [31:0]        pos_y;
  logic [31:0]        pos_z;
  logic signed [15:0] nrm_x;
  logic signed [15:0] nrm_y;
  logic signed [15:0] nrm_z;
  logic [9:0]         entry_index;

  modport source (output valid, operation, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z,
                  entry_index, input ready);
  modport sink (input valid, operation, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z,
                entry_index, output ready);
endinterface

interface vwnm_out_if;
  logic               valid;
  logic               ready;
  logic [9:0]         vertex_index;
  logic [1:0]         status;
  logic [31:0]        out_pos_x;
  logic [31:0]        out_pos_y;
  logic [31:0]        out_pos_z;
  logic signed [15:0] out_nrm_x;
  logic signed [15:0] out_nrm_y;
  logic signed [15:0] out_nrm_z;
  logic [10:0]        unique_count;

  modport source (output valid, vertex_index, status, out_pos_x, out_pos_y, out_pos_z,
                  out_nrm_x, out_nrm_y, out_nrm_z, unique_count, input ready);
  modport sink (input valid, vertex_index, status, out_pos_x, out_pos_y, out_pos_z,
                out_nrm_x, out_nrm_y, out_nrm_z, unique_count, output ready);
endinterface

// File: rtl/vwnm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vwnm_ram #(
  parameter int W  = 32,
  parameter int D  = 1024,
  parameter int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/vwnm_cell.sv
// One cell of the unit-normal chain: settles one bit of q.
module vwnm_cell #(
  parameter int BIT = 14
) (
  input  logic                clk,
  input  logic                rst_n,
  input  vwnm_pkg::vwnm_cell_t din,
  output vwnm_pkg::vwnm_cell_t dout
);
  import vwnm_pkg::*;

  localparam logic [QW-1:0] STEP = QW'(1) << BIT;

  logic [QW-1:0] qt;
  logic [15:0]   t;
  logic          v1_r, v2_r, v3_r;
  vwnm_cell_t    d1_r, d2_r, d3_r;
  vwnm_cell_t    d3_nxt;
  logic [QW-1:0] qt1_r, qt2_r;
  logic          ok1_r, ok2_r;
  logic [31:0]   t2_r;
  logic [63:0]   prod_r;
  logic          pass;

  assign qt   = din.q | STEP;
  assign t    = {qt, 1'b0} - 16'd1;
  assign pass = ok2_r && (prod_r <= 64'(d2_r.rhs));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= din.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // keep the candidate bit only when the test passes
  always_comb begin
    d3_nxt   = d2_r;
    d3_nxt.q = pass ? qt2_r : d2_r.q;
  end

  // square, then scale by n, then decide
  always_ff @(posedge clk) begin
    d1_r   <= din;
    qt1_r  <= qt;
    ok1_r  <= (qt <= Q_ONE);
    t2_r   <= 32'(t) * 32'(t);
    d2_r   <= d1_r;
    qt2_r  <= qt1_r;
    ok2_r  <= ok1_r;
    prod_r <= 64'(t2_r) * 64'(d1_r.n);
    d3_r   <= d3_nxt;
  end

  always_comb begin
    dout       = d3_r;
    dout.valid = v3_r;
  end

endmodule

// File: rtl/vertex_weld_normal_merge.sv
// Top level: vertex welding table with merged, unit-scaled normals.
//
//  channel   dir  handshake            payload
//  in_req    in   valid/ready          operation, pos_x/y/z, nrm_x/y/z, entry_index
//  out_rsp   out  valid/ready          vertex_index, status, out_pos_x/y/z,
//                                      out_nrm_x/y/z, unique_count
//
//  One request at a time. An add scans the stored points one per cycle through the
//  position RAM read port. A read runs through the serial magnitude shift and the
//  15-cell chain that finds the unit normal.
//  Reset (synchronous, rst_n low) empties the table; RAM contents need no clear.
//  A finished result waits in the output register while the next request is taken;
//  only loading a new result waits for out_rsp.ready.
module vertex_weld_normal_merge #(
  parameter int CAPACITY  = vwnm_pkg::CAPACITY_DEF,
  parameter int SUM_WIDTH = vwnm_pkg::SUM_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  vwnm_in_if.sink     in_req,
  vwnm_out_if.source  out_rsp
);
  import vwnm_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int SW   = SUM_WIDTH;
  localparam int CMPW = (CW > IDXW) ? CW : IDXW;
  localparam int NCELL = QW;

  // ---------------------------------------------------------------- state
  vwnm_state_t state_r, state_nxt;

  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      issue_r;       // next scan address
  logic               pend_r;        // RAM data valid for tag_r
  logic [AW-1:0]      tag_r;         // address of the data now on the read port
  logic               op_r;
  logic [31:0]        key_r [3];     // canonical search key
  logic [31:0]        raw_r [3];     // position as given
  logic signed [15:0] nin_r [3];
  logic [IDXW-1:0]    vidx_r, vidx_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [31:0]        opos_r [3];
  logic [SW-1:0]      a_r [3];       // magnitudes of the sums
  logic [2:0]         neg_r;
  logic [29:0]        sq_r [3];
  logic [31:0]        n_r;
  logic [1:0]         feed_r;
  logic [15:0]        nrm_r [3];

  // RAM ports
  logic               pos_we, sum_we;
  logic [AW-1:0]      waddr, pos_raddr, sum_raddr;
  logic [2:0][31:0]   pos_wd, pos_rd;
  logic [2:0][SW-1:0] sum_wd, sum_rd, sum_acc;

  logic in_go, out_load, scan_hit, scan_end, big;
  vwnm_cell_t link [NCELL+1];

  assign in_go = in_req.valid && in_req.ready;

  always_comb begin
    scan_hit = pend_r;
    for (int i = 0; i < 3; i++) begin
      if (canon(pos_rd[i]) != key_r[i]) scan_hit = 1'b0;
    end
  end
  assign scan_end = !pend_r && (issue_r >= count_r);

  always_comb begin
    big = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (a_r[i][SW-1:QW] != '0) big = 1'b1;
    end
  end

  // saturating merge of a matched normal
  always_comb begin
    logic signed [SW:0] wide;
    for (int i = 0; i < 3; i++) begin
      wide = $signed({sum_rd[i][SW-1], sum_rd[i]})
           + $signed({{(SW-15){nin_r[i][15]}}, nin_r[i]});
      if (wide[SW] != wide[SW-1]) begin
        sum_acc[i] = wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      end else begin
        sum_acc[i] = wide[SW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    status_nxt   = status_r;
    vidx_nxt     = vidx_r;
    in_req.ready = 1'b0;
    out_load     = 1'b0;
    pos_we       = 1'b0;
    sum_we       = 1'b0;
    waddr        = tag_r;
    pos_raddr    = (state_r == S_SCAN) ? issue_r[AW-1:0] : AW'(in_req.entry_index);
    sum_raddr    = (state_r == S_SUM_RD) ? tag_r : AW'(in_req.entry_index);
    for (int i = 0; i < 3; i++) begin
      pos_wd[i] = raw_r[i];
      sum_wd[i] = sum_acc[i];
    end
    case (state_r)
      S_IDLE: begin
        in_req.ready = 1'b1;
        if (in_go) begin
          if (in_req.operation == OP_ADD) begin
            state_nxt = S_SCAN;
          end else begin
            vidx_nxt = in_req.entry_index;
            if (CMPW'(in_req.entry_index) >= CMPW'(count_r)) begin
              status_nxt = ST_BADIDX;
              state_nxt  = S_DONE;
            end else begin
              status_nxt = ST_MATCH;
              state_nxt  = S_RD_WAIT;
            end
          end
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          status_nxt = ST_MATCH;
          vidx_nxt   = IDXW'(tag_r);
          state_nxt  = S_SUM_RD;
        end else if (scan_end) begin
          if (count_r == CW'(CAPACITY)) begin
            status_nxt = ST_FULL;
            vidx_nxt   = '0;
            state_nxt  = S_DONE;
          end else begin
            status_nxt = ST_NEW;
            vidx_nxt   = IDXW'(count_r);
            state_nxt  = S_NEW;
          end
        end
      end
      S_SUM_RD: state_nxt = S_SUM_WR;
      S_SUM_WR: begin
        sum_we    = 1'b1;
        state_nxt = S_DONE;
      end
      S_NEW: begin
        pos_we = 1'b1;
        sum_we = 1'b1;
        waddr  = count_r[AW-1:0];
        for (int i = 0; i < 3; i++) begin
          sum_wd[i] = {{(SW-16){nin_r[i][15]}}, nin_r[i]};
        end
        count_nxt = count_r + 1'b1;
        state_nxt = S_DONE;
      end
      S_RD_WAIT: state_nxt = S_SHIFT;
      S_SHIFT:   if (!big) state_nxt = S_SQ;
      S_SQ:      state_nxt = S_NSUM;
      S_NSUM:    state_nxt = S_FEED;
      S_FEED:    if (feed_r == 2'd2) state_nxt = S_DRAIN;
      S_DRAIN:   if (link[NCELL].valid && link[NCELL].tag == 2'd2) state_nxt = S_DONE;
      S_DONE: begin
        if (!out_rsp.valid || out_rsp.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (in_go) begin
      pend_r <= 1'b0;
    end else if (state_r == S_SCAN && !scan_hit) begin
      pend_r <= (issue_r < count_r);
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    vidx_r   <= vidx_nxt;
    if (in_go) begin
      op_r     <= in_req.operation;
      issue_r  <= '0;
      raw_r[0] <= in_req.pos_x;
      raw_r[1] <= in_req.pos_y;
      raw_r[2] <= in_req.pos_z;
      key_r[0] <= canon(in_req.pos_x);
      key_r[1] <= canon(in_req.pos_y);
      key_r[2] <= canon(in_req.pos_z);
      nin_r[0] <= in_req.nrm_x;
      nin_r[1] <= in_req.nrm_y;
      nin_r[2] <= in_req.nrm_z;
    end
    // sequential scan: one stored point per cycle
    if (state_r == S_SCAN && !scan_hit && issue_r < count_r) begin
      issue_r <= issue_r + 1'b1;
      tag_r   <= issue_r[AW-1:0];
    end
    if (state_r == S_RD_WAIT) begin
      for (int i = 0; i < 3; i++) begin
        opos_r[i] <= pos_rd[i];
        neg_r[i]  <= sum_rd[i][SW-1];
        a_r[i]    <= sum_rd[i][SW-1] ? (~sum_rd[i] + 1'b1) : sum_rd[i];
      end
    end
    // bring all magnitudes below 2^15 with one common shift
    if (state_r == S_SHIFT && big) begin
      for (int i = 0; i < 3; i++) a_r[i] <= a_r[i] >> 1;
    end
    if (state_r == S_SQ) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= 30'(a_r[i][QW-1:0]) * 30'(a_r[i][QW-1:0]);
      end
    end
    if (state_r == S_NSUM) begin
      n_r    <= 32'(sq_r[0]) + 32'(sq_r[1]) + 32'(sq_r[2]);
      feed_r <= '0;
    end
    if (state_r == S_FEED) feed_r <= feed_r + 1'b1;
    // collect chain results by component tag; a zero sum yields zero
    if (link[NCELL].valid) begin
      if (n_r == '0) begin
        nrm_r[link[NCELL].tag] <= '0;
      end else if (neg_r[link[NCELL].tag]) begin
        nrm_r[link[NCELL].tag] <= 16'd0 - 16'(link[NCELL].q);
      end else begin
        nrm_r[link[NCELL].tag] <= 16'(link[NCELL].q);
      end
    end
  end

  // ---------------------------------------------------------------- result register
  logic rd_ok;
  assign rd_ok = (op_r == OP_READ) && (status_r == ST_MATCH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_rsp.valid <= 1'b0;
    end else if (out_load) begin
      out_rsp.valid <= 1'b1;
    end else if (out_rsp.ready) begin
      out_rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rsp.vertex_index <= vidx_r;
      out_rsp.status       <= status_r;
      out_rsp.out_pos_x    <= rd_ok ? opos_r[0] : 32'd0;
      out_rsp.out_pos_y    <= rd_ok ? opos_r[1] : 32'd0;
      out_rsp.out_pos_z    <= rd_ok ? opos_r[2] : 32'd0;
      out_rsp.out_nrm_x    <= rd_ok ? nrm_r[0] : 16'd0;
      out_rsp.out_nrm_y    <= rd_ok ? nrm_r[1] : 16'd0;
      out_rsp.out_nrm_z    <= rd_ok ? nrm_r[2] : 16'd0;
      out_rsp.unique_count <= 11'(count_r);
    end
  end

  // ---------------------------------------------------------------- storage
  vwnm_ram #(.W(96), .D(CAPACITY)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (waddr),
    .wdata (pos_wd),
    .raddr (pos_raddr),
    .rdata (pos_rd)
  );

  vwnm_ram #(.W(3*SW), .D(CAPACITY)) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (waddr),
    .wdata (sum_wd),
    .raddr (sum_raddr),
    .rdata (sum_rd)
  );

  // ---------------------------------------------------------------- unit-normal chain
  // Components x, y, z enter on consecutive cycles; each cell fixes one bit of
  // q, the largest value with (2q-1)^2 * n <= a^2 * 2^30, from the top bit down.
  always_comb begin
    link[0].valid = (state_r == S_FEED);
    link[0].tag   = feed_r;
    link[0].q     = '0;
    link[0].rhs   = {sq_r[feed_r], 30'd0};
    link[0].n     = n_r;
  end

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    vwnm_cell #(.BIT(NCELL - 1 - g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .din   (link[g]),
      .dout  (link[g+1])
    );
  end

  // ---------------------------------------------------------------- checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_new_room: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_NEW |-> count_r < CW'(CAPACITY))
    else $error("new entry written into full table");

  a_scan_tag: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && pend_r) |-> CW'(tag_r) < count_r)
    else $error("scan compared an unwritten entry");

  a_chain_drain: assert property (@(posedge clk) disable iff (!rst_n)
    link[NCELL].valid |-> state_r == S_DRAIN)
    else $error("chain result outside drain");

endmodule

// File: bench/vwnm_checker.sv
// Response checker: tracks the weld table, predicts each response and compares it.
module vwnm_checker (
  input  logic       clk,
  input  logic       rst_n,
  vwnm_in_if         in_ch,
  vwnm_out_if        out_ch,
  output int         fails,
  output int         pending,
  output int         n_checked
);
  import vwnm_pkg::*;

  localparam int DEPTH = CAPACITY_DEF;
  localparam longint SUM_MAX = (64'sd1 <<< (SUM_WIDTH_DEF - 1)) - 1;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  typedef struct {
    logic [9:0]  vertex_index;
    logic [1:0]  status;
    logic [31:0] px, py, pz;
    logic [15:0] nx, ny, nz;
    logic [10:0] unique_count;
  } weld_rsp_t;

  weld_rsp_t   rsp_q[$];
  logic [31:0] pt_x[DEPTH], pt_y[DEPTH], pt_z[DEPTH];
  longint      sum_x[DEPTH], sum_y[DEPTH], sum_z[DEPTH];
  int          entries;

  function automatic logic [31:0] zero_fold(input logic [31:0] v);
    return (v == NEG_ZERO) ? 32'd0 : v;
  endfunction

  function automatic longint clamp_sum(input longint v);
    if (v > SUM_MAX) return SUM_MAX;
    if (v < SUM_MIN) return SUM_MIN;
    return v;
  endfunction

  // largest q with (2q-1)^2 * n <= a^2 * 2^30
  function automatic longint unsigned unit_root(input longint unsigned a,
                                                input longint unsigned n);
    longint unsigned lo, hi, mid, t, rhs;
    lo = 0;
    hi = 16384;
    rhs = (a * a) << 30;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 2 * mid - 1;
      if (t * t * n <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic void unit_normal(input longint sx, sy, sz,
                                      output logic [15:0] ox, oy, oz);
    longint          s[3];
    longint unsigned a[3], n, q;
    logic [15:0]     o[3];
    int              k;
    s[0] = sx; s[1] = sy; s[2] = sz;
    for (int i = 0; i < 3; i++) a[i] = (s[i] < 0) ? -s[i] : s[i];
    k = 0;
    while (((a[0] >> k) >= 32768 || (a[1] >> k) >= 32768 || (a[2] >> k) >= 32768)
           && k < 40)
      k++;
    n = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = a[i] >> k;
      n += a[i] * a[i];
    end
    for (int i = 0; i < 3; i++) begin
      q = (n == 0) ? 0 : unit_root(a[i], n);
      o[i] = (s[i] < 0) ? 16'(-q) : 16'(q);
    end
    ox = o[0]; oy = o[1]; oz = o[2];
  endfunction

  function automatic weld_rsp_t predict_weld();
    weld_rsp_t r;
    int        hit;
    r = '{default: 0};
    if (in_ch.operation == OP_ADD) begin
      hit = -1;
      for (int i = 0; i < entries; i++)
        if (hit < 0 && zero_fold(pt_x[i]) == zero_fold(in_ch.pos_x) &&
            zero_fold(pt_y[i]) == zero_fold(in_ch.pos_y) &&
            zero_fold(pt_z[i]) == zero_fold(in_ch.pos_z))
          hit = i;
      if (hit >= 0) begin
        sum_x[hit] = clamp_sum(sum_x[hit] + longint'(in_ch.nrm_x));
        sum_y[hit] = clamp_sum(sum_y[hit] + longint'(in_ch.nrm_y));
        sum_z[hit] = clamp_sum(sum_z[hit] + longint'(in_ch.nrm_z));
        r.vertex_index = 10'(hit);
        r.status = ST_MATCH;
      end else if (entries >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pt_x[entries] = in_ch.pos_x;
        pt_y[entries] = in_ch.pos_y;
        pt_z[entries] = in_ch.pos_z;
        sum_x[entries] = longint'(in_ch.nrm_x);
        sum_y[entries] = longint'(in_ch.nrm_y);
        sum_z[entries] = longint'(in_ch.nrm_z);
        r.vertex_index = 10'(entries);
        r.status = ST_NEW;
        entries++;
      end
    end else begin
      r.vertex_index = in_ch.entry_index;
      if (int'(in_ch.entry_index) >= entries) begin
        r.status = ST_BADIDX;
      end else begin
        r.status = ST_MATCH;
        r.px = pt_x[in_ch.entry_index];
        r.py = pt_y[in_ch.entry_index];
        r.pz = pt_z[in_ch.entry_index];
        unit_normal(sum_x[in_ch.entry_index], sum_y[in_ch.entry_index],
                    sum_z[in_ch.entry_index], r.nx, r.ny, r.nz);
      end
    end
    r.unique_count = 11'(entries);
    return r;
  endfunction

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    weld_rsp_t e;
    if (!rst_n) begin
      entries = 0;
      rsp_q.delete();
      fails = 0;
      n_checked = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (rsp_q.size() == 0) begin
          $error("response with no request outstanding");
          fails++;
        end else begin
          e = rsp_q.pop_front();
          check_field("vertex_index", e.vertex_index, out_ch.vertex_index);
          check_field("status", e.status, out_ch.status);
          check_field("out_pos_x", e.px, out_ch.out_pos_x);
          check_field("out_pos_y", e.py, out_ch.out_pos_y);
          check_field("out_pos_z", e.pz, out_ch.out_pos_z);
          check_field("out_nrm_x", e.nx, $unsigned(out_ch.out_nrm_x));
          check_field("out_nrm_y", e.ny, $unsigned(out_ch.out_nrm_y));
          check_field("out_nrm_z", e.nz, $unsigned(out_ch.out_nrm_z));
          check_field("unique_count", e.unique_count, out_ch.unique_count);
          n_checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) rsp_q = {rsp_q, predict_weld()};
    end
    pending = rsp_q.size();
  end

endmodule

// File: bench/tb.sv
// Testbench top: drives requests and response backpressure, reports the verdict.
module tb;
  import vwnm_pkg::*;

  logic clk = 1'b0;
  logic rst_n;
  int   fails, pending, n_checked;
  int   n_adds, n_reads;
  bit   calm;       // no idling in the final stretch
  bit   hold_req;   // asks the response side for one long stall
  logic [31:0] pool_x[24], pool_y[24], pool_z[24];

  vwnm_in_if  in_if ();
  vwnm_out_if out_if ();

  vertex_weld_normal_merge u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_if),
    .out_rsp (out_if)
  );

  vwnm_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .fails     (fails),
    .pending   (pending),
    .n_checked (n_checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hang guard: far beyond the slowest legal run (long table scans dominate).
  initial begin
    #40000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Response side: random stall bursts, one long hold-off on request, then steady.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // One request: hold valid until the block takes it, then maybe idle a burst.
  task automatic send_req(input logic op, input logic [31:0] x, y, z,
                          input logic [15:0] nx, ny, nz, input logic [9:0] idx);
    in_if.valid       <= 1'b1;
    in_if.operation   <= op;
    in_if.pos_x       <= x;
    in_if.pos_y       <= y;
    in_if.pos_z       <= z;
    in_if.nrm_x       <= nx;
    in_if.nrm_y       <= ny;
    in_if.nrm_z       <= nz;
    in_if.entry_index <= idx;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (op == OP_ADD) n_adds++;
    else n_reads++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] rand_nrm();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  // pool coordinate, with plus/minus zero swapped now and then
  function automatic logic [31:0] zero_flip(input logic [31:0] v);
    if ((v == 32'd0 || v == NEG_ZERO) && $urandom_range(0, 1)) return v ^ NEG_ZERO;
    return v;
  endfunction

  initial begin
    int p, wait_cnt;
    logic [9:0] ridx;
    calm = 0;
    hold_req = 0;
    n_adds = 0;
    n_reads = 0;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.operation <= OP_ADD;
    in_if.pos_x <= '0;
    in_if.pos_y <= '0;
    in_if.pos_z <= '0;
    in_if.nrm_x <= '0;
    in_if.nrm_y <= '0;
    in_if.nrm_z <= '0;
    in_if.entry_index <= '0;

    // point pool: zeros, NaN, infinities, all-ones, then random patterns
    pool_x[0] = 32'd0;        pool_y[0] = 32'd0;        pool_z[0] = 32'd0;
    pool_x[1] = 32'h7FC00000; pool_y[1] = 32'h3F800000; pool_z[1] = 32'hFFFFFFFF;
    pool_x[2] = 32'h7F800000; pool_y[2] = 32'hFF800000; pool_z[2] = NEG_ZERO;
    pool_x[3] = 32'hFFFFFFFF; pool_y[3] = 32'hFFFFFFFF; pool_z[3] = 32'hFFFFFFFF;
    for (int i = 4; i < 24; i++) begin
      pool_x[i] = $urandom;
      pool_y[i] = $urandom;
      pool_z[i] = (i % 5 == 0) ? 32'd0 : $urandom;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: read of empty table, zero normal, minus zero welding, NaN match,
    // normal extremes, reads at and beyond the count
    send_req(OP_READ, 0, 0, 0, 0, 0, 0, 10'd0);
    send_req(OP_ADD, 32'd0, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0, 0);
    send_req(OP_ADD, NEG_ZERO, 32'd0, NEG_ZERO, 16'd0, 16'd0, 16'd0, 0);
    send_req(OP_READ, 0, 0, 0, 0, 0, 0, 10'd0);
    send_req(OP_ADD, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
             16'sd16384, -16'sd16384, 16'sd16384, 0);
    send_req(OP_ADD, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
             16'sd16384, -16'sd16384, 16'sd16384, 0);
    send_req(OP_READ, 0, 0, 0, 0, 0, 0, 10'd1);
    send_req(OP_ADD, 32'h7FC00000, 32'h3F800000, NEG_ZERO, -16'sd16384, 16'd1, 16'd0, 0);
    send_req(OP_ADD, 32'h7FC00000, 32'h3F800000, 32'd0, -16'sd16384, -16'sd1, 16'd0, 0);
    send_req(OP_ADD, 32'h7FC00001, 32'h3F800000, 32'd0, 16'd0, 16'd0, -16'sd16384, 0);
    send_req(OP_ADD, 32'd0, 32'd0, 32'd1, 16'd1, -16'sd1, 16'd1, 0);
    send_req(OP_READ, 0, 0, 0, 0, 0, 0, 10'd2);
    send_req(OP_READ, 0, 0, 0, 0, 0, 0, 10'd3);
    send_req(OP_READ, 0, 0, 0, 0, 0, 0, 10'd4);
    send_req(OP_READ, 0, 0, 0, 0, 0, 0, 10'd5);
    send_req(OP_READ, 0, 0, 0, 0, 0, 0, 10'd1023);

    // random mix: mostly pool points so matches are common, some fresh points
    for (int n = 0; n < 310; n++) begin
      if (n == 150) hold_req = 1;
      if (n == 250) begin
        // hammer one point so its sums grow large and need a wide shift
        p = $urandom_range(4, 23);
        for (int j = 0; j < 40; j++)
          send_req(OP_ADD, pool_x[p], pool_y[p], pool_z[p], 16'sd16384,
                   (j % 7 == 0) ? 16'sd16384 : -16'sd16384, rand_nrm(), 0);
        send_req(OP_READ, 0, 0, 0, 0, 0, 0, 10'(u_chk_entries_hint(p)));
      end
      if ($urandom_range(0, 3) == 0) begin
        ridx = ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(0, 30));
        send_req(OP_READ, $urandom, $urandom, $urandom, rand_nrm(), rand_nrm(),
                 rand_nrm(), ridx);
      end else if ($urandom_range(0, 3) != 0) begin
        p = $urandom_range(0, 23);
        send_req(OP_ADD, zero_flip(pool_x[p]), zero_flip(pool_y[p]), zero_flip(pool_z[p]),
                 rand_nrm(), rand_nrm(), rand_nrm(), 10'($urandom));
      end else begin
        send_req(OP_ADD, $urandom, $urandom, $urandom, rand_nrm(), rand_nrm(),
                 rand_nrm(), 10'($urandom));
      end
    end

    // final stretch, no idling: fresh points back to back, then edge reads
    calm = 1;
    for (int j = 0; j < 30; j++)
      send_req(OP_ADD, 32'hA5000000 | j, 32'h5A000000 ^ j, 32'h00C0FFEE, rand_nrm(),
               rand_nrm(), rand_nrm(), 0);
    send_req(OP_ADD, pool_x[3], pool_y[3], pool_z[3], 16'sd16384, 16'sd16384, 16'd0, 0);
    send_req(OP_READ, 0, 0, 0, 0, 0, 0, 10'd1023);
    send_req(OP_READ, 0, 0, 0, 0, 0, 0, 10'd0);
    send_req(OP_ADD, 32'h12345678, 32'h9ABCDEF0, 32'h0, 16'd5, 16'd5, 16'd5, 0);
    in_if.valid <= 1'b0;

    wait_cnt = 0;
    do begin
      @(posedge clk);
      wait_cnt++;
    end while (pending != 0 && wait_cnt < 20000);
    if (pending != 0) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    repeat (100) @(posedge clk);

    $display("covered %0d adds and %0d reads, %0d responses compared", n_adds, n_reads,
             n_checked);
    $display("includes zero welding, NaN patterns, large merged sums and a long stall");
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // the hammered pool point: read a low entry, where it most likely sits
  function automatic int u_chk_entries_hint(input int p);
    return p % 8;
  endfunction

endmodule
